>>> rtl/core/ternary_byte_prefix_matcher_assert.svh
// ----------------------------------------------------------------------------
// Ternary byte prefix matcher assertion macros
// Shared concurrent assertion forms, clocked and held off during reset.
// ----------------------------------------------------------------------------
`ifndef TERNARY_BYTE_PREFIX_MATCHER_ASSERT_SVH
`define TERNARY_BYTE_PREFIX_MATCHER_ASSERT_SVH

// Same-cycle implication
`define TBPM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("tbpm assertion failed");

// Next-cycle implication
`define TBPM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("tbpm assertion failed");

`endif

>>> rtl/core/tbpm_pkg.sv
// ----------------------------------------------------------------------------
// tbpm_pkg
// Shared types, codes and helpers of the ternary byte prefix matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package tbpm_pkg;

  // Pattern geometry
  localparam int unsigned MaxPatBytes = 8;
  localparam int unsigned PatW        = 8 * MaxPatBytes;
  localparam int unsigned LenW        = 4;
  localparam int unsigned OffW        = $clog2(MaxPatBytes);

  // Queue geometry
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Input function codes
  localparam logic FUNC_MATCH = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Result kind codes
  localparam logic KIND_VERDICT = 1'b0;
  localparam logic KIND_ANSWER  = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_MASK  = 2'd0;
  localparam logic [1:0] REG_VALUE = 2'd1;
  localparam logic [1:0] REG_LEN   = 2'd2;

  // No matching byte
  localparam logic [8:0] NO_CHAR = 9'h100;

  // Work record from front to back
  typedef struct packed {
    logic            kind;
    logic            matched;
    logic [LenW-1:0] mlen;
    logic            qhit;
    logic [OffW-1:0] qoff;
    logic [7:0]      start;
  } entry_t;

  // Pick one pattern byte out of a packed mask or value word
  function automatic logic [7:0] pat_byte(input logic [PatW-1:0] vec,
                                          input logic [OffW-1:0] idx);
    pat_byte = vec[idx*8 +: 8];
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/ternary_byte_prefix_matcher.sv
// ----------------------------------------------------------------------------
// ternary_byte_prefix_matcher
// Anchored prefix matcher against up to eight ternary (mask, value) bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one item per transfer:
//   func_i = 0 streams one string byte (last_byte_i marks the end of the
//   string), func_i = 1 asks for the smallest byte at or above start_char_i
//   that fits pattern position query_offset_i.
//   Output channel (out_valid_o / out_stall_i) carries one result per query
//   and one verdict per string end; other string bytes give no result.
//   Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
//   (0 mask, 1 value, 2 length); write only while the block is idle.
//   Throughput: one item per cycle while in_stall_o is low; the match step in
//   the front and the 256-way search in the back are combinational.
//   Path: each item's record is registered in the queue and then in the
//   output register before its result is presented on the output.
//   Stall: a stalled result holds in the output register; the two-entry
//   queue then fills and in_stall_o rises once it is full.
//   Reset: match state and queue empty, mask and value 0, length 1.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ternary_byte_prefix_matcher_assert.svh"

module ternary_byte_prefix_matcher (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        func_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  input  wire logic [3:0]  query_offset_i,
  input  wire logic [7:0]  start_char_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             kind_o,
  output logic             matched_o,
  output logic [3:0]       matched_len_o,
  output logic [8:0]       next_char_o
);

  logic [tbpm_pkg::PatW-1:0] mask_q, value_q;
  logic [tbpm_pkg::LenW-1:0] len_q;
  logic                      push, pop, q_full, head_valid;
  tbpm_pkg::entry_t          push_entry, head_entry;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q  <= '0;
      value_q <= '0;
      len_q   <= tbpm_pkg::LenW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tbpm_pkg::REG_MASK:  mask_q  <= cfg_wdata_i;
        tbpm_pkg::REG_VALUE: value_q <= cfg_wdata_i;
        tbpm_pkg::REG_LEN:   len_q   <= cfg_wdata_i[tbpm_pkg::LenW-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = q_full;

  tbpm_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pat_mask_i     (mask_q),
    .pat_value_i    (value_q),
    .pat_len_i      (len_q),
    .in_valid_i     (in_valid_i),
    .q_full_i       (q_full),
    .func_i         (func_i),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .query_offset_i (query_offset_i),
    .start_char_i   (start_char_i),
    .push_o         (push),
    .push_entry_o   (push_entry)
  );

  tbpm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_entry_o (head_entry)
  );

  tbpm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pat_mask_i    (mask_q),
    .pat_value_i   (value_q),
    .head_valid_i  (head_valid),
    .head_entry_i  (head_entry),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .matched_o     (matched_o),
    .matched_len_o (matched_len_o),
    .next_char_o   (next_char_o)
  );

  // A query answer never carries verdict fields
  `TBPM_ASSERT_IMP(a_answer_clean, clk_i, rst_ni,
    out_valid_o && (kind_o == tbpm_pkg::KIND_ANSWER), !matched_o && (matched_len_o == 4'd0))

  // A full match always reports a nonzero length
  `TBPM_ASSERT_IMP(a_match_len, clk_i, rst_ni,
    out_valid_o && (kind_o == tbpm_pkg::KIND_VERDICT) && matched_o, matched_len_o != 4'd0)

  // A query answer is a byte or the no-match code
  `TBPM_ASSERT_IMP(a_answer_range, clk_i, rst_ni,
    out_valid_o && (kind_o == tbpm_pkg::KIND_ANSWER), !next_char_o[8] || (next_char_o[7:0] == 8'd0))

  // A query transfer into an empty pipe sits at the queue head in the next cycle
  `TBPM_ASSERT_NXT(a_query_flows, clk_i, rst_ni,
    in_valid_i && !in_stall_o && (func_i == tbpm_pkg::FUNC_QUERY) && !head_valid && !out_valid_o,
    head_valid)

endmodule

`default_nettype wire

>>> rtl/core/tbpm_front.sv
// ----------------------------------------------------------------------------
// tbpm_front
// Accepts items, steps the anchored match state and queues result work.
// ----------------------------------------------------------------------------
`default_nettype none

module tbpm_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [tbpm_pkg::PatW-1:0]     pat_mask_i,
  input  wire logic [tbpm_pkg::PatW-1:0]     pat_value_i,
  input  wire logic [tbpm_pkg::LenW-1:0]     pat_len_i,
  input  wire logic                          in_valid_i,
  input  wire logic                          q_full_i,
  input  wire logic                          func_i,
  input  wire logic [7:0]                    data_byte_i,
  input  wire logic                          last_byte_i,
  input  wire logic [3:0]                    query_offset_i,
  input  wire logic [7:0]                    start_char_i,
  output logic                               push_o,
  output tbpm_pkg::entry_t                   push_entry_o
);

  logic [tbpm_pkg::LenW-1:0] pos_q, pos_d;
  logic                      miss_q, miss_d;
  logic [tbpm_pkg::LenW-1:0] len_eff;
  logic                      accept;
  logic                      byte_ok;
  logic [7:0]                cur_mask;
  logic [7:0]                cur_value;

  // Clamp pattern length into 1..MaxPatBytes
  always_comb begin
    if (pat_len_i == '0) begin
      len_eff = tbpm_pkg::LenW'(1);
    end else if (pat_len_i > tbpm_pkg::LenW'(tbpm_pkg::MaxPatBytes)) begin
      len_eff = tbpm_pkg::LenW'(tbpm_pkg::MaxPatBytes);
    end else begin
      len_eff = pat_len_i;
    end
  end

  assign accept = in_valid_i && !q_full_i;

  // Compare the string byte against the pattern byte at the current position
  assign cur_mask  = tbpm_pkg::pat_byte(pat_mask_i, pos_q[tbpm_pkg::OffW-1:0]);
  assign cur_value = tbpm_pkg::pat_byte(pat_value_i, pos_q[tbpm_pkg::OffW-1:0]);
  assign byte_ok   = (data_byte_i & cur_mask) == cur_value;

  // Advance match state and build the queued record
  always_comb begin
    pos_d        = pos_q;
    miss_d       = miss_q;
    push_o       = 1'b0;
    push_entry_o = '0;
    if (accept) begin
      if (func_i == tbpm_pkg::FUNC_QUERY) begin
        push_o             = 1'b1;
        push_entry_o.kind  = tbpm_pkg::KIND_ANSWER;
        push_entry_o.qhit  = query_offset_i < len_eff;
        push_entry_o.qoff  = query_offset_i[tbpm_pkg::OffW-1:0];
        push_entry_o.start = start_char_i;
      end else begin
        if (!miss_q && (pos_q < len_eff)) begin
          if (byte_ok) begin
            pos_d = pos_q + tbpm_pkg::LenW'(1);
          end else begin
            miss_d = 1'b1;
          end
        end
        if (last_byte_i) begin
          push_o               = 1'b1;
          push_entry_o.kind    = tbpm_pkg::KIND_VERDICT;
          push_entry_o.matched = !miss_d && (pos_d >= len_eff);
          push_entry_o.mlen    = (pos_d < len_eff) ? pos_d : len_eff;
          pos_d                = '0;
          miss_d               = 1'b0;
        end
      end
    end
  end

  // Hold match state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      miss_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      miss_q <= miss_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/tbpm_queue.sv
// ----------------------------------------------------------------------------
// tbpm_queue
// Two-entry queue of work records between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module tbpm_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire tbpm_pkg::entry_t  push_entry_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   head_valid_o,
  output tbpm_pkg::entry_t       head_entry_o
);

  tbpm_pkg::entry_t                store_q [tbpm_pkg::QDepth];
  logic [tbpm_pkg::QPtrW-1:0]      wr_q, rd_q;
  logic [tbpm_pkg::QCntW-1:0]      cnt_q, cnt_d;

  assign full_o       = cnt_q == tbpm_pkg::QCntW'(tbpm_pkg::QDepth);
  assign head_valid_o = cnt_q != '0;
  assign head_entry_o = store_q[rd_q];

  // Track fill level
  always_comb begin
    cnt_d = cnt_q;
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + tbpm_pkg::QCntW'(1);
      2'b01:   cnt_d = cnt_q - tbpm_pkg::QCntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  // Advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= wr_q + tbpm_pkg::QPtrW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + tbpm_pkg::QPtrW'(1);
      end
    end
  end

  // Store pushed records
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_q] <= push_entry_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/tbpm_back.sv
// ----------------------------------------------------------------------------
// tbpm_back
// Runs the next-byte search for queries and registers each result.
// ----------------------------------------------------------------------------
`default_nettype none

module tbpm_back (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [tbpm_pkg::PatW-1:0] pat_mask_i,
  input  wire logic [tbpm_pkg::PatW-1:0] pat_value_i,
  input  wire logic                      head_valid_i,
  input  wire tbpm_pkg::entry_t          head_entry_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic                           kind_o,
  output logic                           matched_o,
  output logic [3:0]                     matched_len_o,
  output logic [8:0]                     next_char_o
);

  logic       valid_q;
  logic       kind_q, matched_q;
  logic [3:0] mlen_q;
  logic [8:0] next_q;
  logic [7:0] q_mask, q_value;
  logic [8:0] answer;

  assign q_mask  = tbpm_pkg::pat_byte(pat_mask_i, head_entry_i.qoff);
  assign q_value = tbpm_pkg::pat_byte(pat_value_i, head_entry_i.qoff);

  // Find the lowest byte at or above start that fits the ternary byte
  always_comb begin
    logic [7:0] cb;
    answer = tbpm_pkg::NO_CHAR;
    for (int c = 255; c >= 0; c--) begin
      cb = 8'(c);
      if (((cb & q_mask) == q_value) && (cb >= head_entry_i.start)) begin
        answer = {1'b0, cb};
      end
    end
    if (!head_entry_i.qhit) begin
      answer = tbpm_pkg::NO_CHAR;
    end
  end

  // Load the output register when it is free or being emptied
  assign pop_o = head_valid_i && (!valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q <= head_entry_i.kind;
      if (head_entry_i.kind == tbpm_pkg::KIND_ANSWER) begin
        matched_q <= 1'b0;
        mlen_q    <= '0;
        next_q    <= answer;
      end else begin
        matched_q <= head_entry_i.matched;
        mlen_q    <= head_entry_i.mlen;
        next_q    <= '0;
      end
    end
  end

  assign out_valid_o   = valid_q;
  assign kind_o        = kind_q;
  assign matched_o     = matched_q;
  assign matched_len_o = mlen_q;
  assign next_char_o   = next_q;

endmodule

`default_nettype wire
